[hw/rtl/lsl_pkg.sv]
// Shared types, constants and register codes for the lidar sector speed limiter.
// No dependencies; the top level, front end and back end import this package.
`default_nettype none

package lsl_pkg;

	localparam int unsigned CMD_TIMEOUT_DEFAULT = 3;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [15:0] NO_READING = 16'hFFFF;
	localparam int unsigned DIV_STEPS = 16;

	// request kinds on the input tuser
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_CMD    = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// sector order in the minima arrays
	localparam int unsigned SEC_FWD   = 0;
	localparam int unsigned SEC_REAR  = 1;
	localparam int unsigned SEC_LEFT  = 2;
	localparam int unsigned SEC_RIGHT = 3;
	localparam int unsigned NUM_SECTORS = 4;

	// configuration register indexes
	localparam logic [2:0] CFG_STOP_DISTANCE = 3'd0;
	localparam logic [2:0] CFG_RAMP_WIDTH    = 3'd1;
	localparam logic [2:0] CFG_FWD_HALF      = 3'd2;
	localparam logic [2:0] CFG_SIDE_START    = 3'd3;
	localparam logic [2:0] CFG_SIDE_END      = 3'd4;
	localparam logic [2:0] CFG_RANGE_MIN     = 3'd5;
	localparam logic [2:0] CFG_RANGE_MAX     = 3'd6;
	localparam logic [2:0] CFG_SCAN_TIMEOUT  = 3'd7;

	typedef struct packed {
		logic [15:0] stop_distance;
		logic [15:0] ramp_width;
		logic [14:0] forward_half_angle;
		logic [14:0] side_start_angle;
		logic [14:0] side_end_angle;
		logic [15:0] range_minimum;
		logic [15:0] range_maximum;
		logic [7:0]  scan_timeout_ticks;
	} lsl_cfg_t;

	localparam lsl_cfg_t CFG_RESET = '{
		stop_distance:      16'd100,
		ramp_width:         16'd250,
		forward_half_angle: 15'd6372,
		side_start_angle:   15'd7282,
		side_end_angle:     15'd25486,
		range_minimum:      16'd0,
		range_maximum:      16'd65534,
		scan_timeout_ticks: 8'd5
	};

	typedef enum logic [1:0] {
		OP_PASS,
		OP_ZERO,
		OP_SCALE
	} lsl_op_t;

	// one velocity component and what the back end must do with it
	typedef struct packed {
		logic signed [15:0] val;
		lsl_op_t            op;
		logic [15:0]        num;
	} lsl_comp_t;

	typedef struct packed {
		lsl_comp_t lin;
		lsl_comp_t ang;
		logic      watchdog;
	} lsl_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} lsl_bk_state_t;

endpackage

`default_nettype wire

[hw/rtl/lidar_sector_speed_limiter_top.sv]
// Lidar sector speed limiter: lidar samples and ticks are absorbed by the front end as they
// are accepted; velocity commands and watchdog stops become jobs in a short queue. The back
// end takes one job at a time: it fetches the job, then handles each component with a pass
// or a zero, or with a slowdown scale (one product, then a 16-step divide by the slowdown
// zone), and then loads the output register once the output is free. The input stalls only
// while the queue is full. Configuration writes take effect at once and belong in quiet
// periods.
// Depends on lsl_pkg, lsl_front, lsl_queue and lsl_back.
`default_nettype none

module lidar_sector_speed_limiter_top import lsl_pkg::*; #(
	parameter int unsigned CMD_TIMEOUT_TICKS = CMD_TIMEOUT_DEFAULT,
	parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// range_mm[15:0], beam_angle[31:16], linear_vel[47:32], angular_vel[63:48]
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,   // scan_last
	input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// out_linear[15:0], out_angular[31:16]
	output      logic [31:0] m_axis_tdata,
	output      logic [0:0]  m_axis_tuser    // from_watchdog[0]
);

	lsl_cfg_t cfg_q;
	lsl_job_t push_job, pop_job;
	logic     q_push, q_full, q_pop, q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STOP_DISTANCE: cfg_q.stop_distance      <= cfg_wdata;
				CFG_RAMP_WIDTH:    cfg_q.ramp_width         <= cfg_wdata;
				CFG_FWD_HALF:      cfg_q.forward_half_angle <= cfg_wdata[14:0];
				CFG_SIDE_START:    cfg_q.side_start_angle   <= cfg_wdata[14:0];
				CFG_SIDE_END:      cfg_q.side_end_angle     <= cfg_wdata[14:0];
				CFG_RANGE_MIN:     cfg_q.range_minimum      <= cfg_wdata;
				CFG_RANGE_MAX:     cfg_q.range_maximum      <= cfg_wdata;
				CFG_SCAN_TIMEOUT:  cfg_q.scan_timeout_ticks <= cfg_wdata[7:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	lsl_front #(
		.CMD_TIMEOUT_TICKS(CMD_TIMEOUT_TICKS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (push_job)
	);

	lsl_queue #(
		.WIDTH($bits(lsl_job_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_job),
		.empty     (q_empty)
	);

	lsl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.zone          (cfg_q.ramp_width),
		.job_valid     (!q_empty),
		.job           (pop_job),
		.job_pop       (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

[hw/rtl/lsl_queue.sv]
// Short job queue between the front and back ends of the speed limiter.
// Depends on nothing but its parameters.
`default_nettype none

module lsl_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic [WIDTH-1:0] pop_data,
	output      logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lsl_front.sv]
// Front end: takes items, tracks sector minima and ages, makes command and watchdog jobs.
// Depends on lsl_pkg.
`default_nettype none

module lsl_front import lsl_pkg::*; #(
	parameter int unsigned CMD_TIMEOUT_TICKS = CMD_TIMEOUT_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lsl_cfg_t    cfg,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        q_full,
	output      logic        q_push,
	output      lsl_job_t    q_job
);

	logic [15:0] run_min_q [NUM_SECTORS];
	logic [15:0] lat_min_q [NUM_SECTORS];
	logic [15:0] run_min_d [NUM_SECTORS];
	logic        scan_present_q;
	logic [7:0]  scan_age_q, cmd_age_q;
	logic [7:0]  scan_age_inc, cmd_age_inc;

	logic               accept;
	logic [15:0]        rng;
	logic signed [15:0] beam, lin, angv;
	logic signed [16:0] beam_ext, rear_ext, neg_ext, half_s, lo_s, hi_s;
	logic [14:0]        side_lo, side_hi;
	logic               rng_ok, wd_fire, fresh;
	logic [NUM_SECTORS-1:0] hit;
	lsl_comp_t          lin_c, ang_c;

	function automatic lsl_comp_t classify(input logic signed [15:0] v,
			input logic [15:0] m, input logic [15:0] stop, input logic [15:0] zone);
		lsl_comp_t   c;
		logic [16:0] band;
		band  = {1'b0, stop} + {1'b0, zone};
		c.val = v;
		c.num = m - stop;
		c.op  = OP_PASS;
		if (v == '0 || m == NO_READING) begin
			c.op = OP_PASS;
		end else if (m < stop) begin
			c.op = OP_ZERO;
		end else if ({1'b0, m} < band && zone != '0) begin
			c.op = OP_SCALE;
		end
		return c;
	endfunction

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !q_full;

	assign rng  = s_axis_tdata[15:0];
	assign beam = $signed(s_axis_tdata[31:16]);
	assign lin  = $signed(s_axis_tdata[47:32]);
	assign angv = $signed(s_axis_tdata[63:48]);

	always_comb begin
		beam_ext = {beam[15], beam};
		// rotate by pi: flipping the sign bit adds 32768 modulo 2^16
		rear_ext = {~beam[15], ~beam[15], beam[14:0]};
		neg_ext  = -beam_ext;
		half_s   = $signed({2'b00, cfg.forward_half_angle});
		if (cfg.side_start_angle > cfg.side_end_angle) begin
			side_lo = cfg.side_end_angle;
			side_hi = cfg.side_start_angle;
		end else begin
			side_lo = cfg.side_start_angle;
			side_hi = cfg.side_end_angle;
		end
		lo_s = $signed({2'b00, side_lo});
		hi_s = $signed({2'b00, side_hi});

		rng_ok = (rng != NO_READING) && (rng >= cfg.range_minimum)
			&& (rng <= cfg.range_maximum);
		hit[SEC_FWD]   = (beam_ext >= -half_s) && (beam_ext <= half_s);
		hit[SEC_REAR]  = (rear_ext >= -half_s) && (rear_ext <= half_s);
		hit[SEC_LEFT]  = (beam_ext >= lo_s) && (beam_ext <= hi_s);
		hit[SEC_RIGHT] = (neg_ext >= lo_s) && (neg_ext <= hi_s);

		for (int i = 0; i < NUM_SECTORS; i++) begin
			run_min_d[i] = (rng_ok && hit[i] && rng < run_min_q[i]) ? rng : run_min_q[i];
		end
	end

	assign scan_age_inc = (scan_age_q == 8'hFF) ? scan_age_q : scan_age_q + 8'd1;
	assign cmd_age_inc  = (cmd_age_q == 8'hFF) ? cmd_age_q : cmd_age_q + 8'd1;
	assign wd_fire      = cmd_age_inc > 8'(CMD_TIMEOUT_TICKS);
	assign fresh        = scan_present_q && (scan_age_q <= cfg.scan_timeout_ticks);

	always_comb begin
		lin_c = classify(lin, (lin > 0) ? lat_min_q[SEC_FWD] : lat_min_q[SEC_REAR],
			cfg.stop_distance, cfg.ramp_width);
		ang_c = classify(angv, (angv > 0) ? lat_min_q[SEC_LEFT] : lat_min_q[SEC_RIGHT],
			cfg.stop_distance, cfg.ramp_width);
		if (!fresh) begin
			lin_c.op = OP_PASS;
			ang_c.op = OP_PASS;
		end

		q_push = 1'b0;
		q_job  = '{lin: lin_c, ang: ang_c, watchdog: 1'b0};
		if (accept && s_axis_tuser == REQ_CMD) begin
			q_push = 1'b1;
		end else if (accept && s_axis_tuser == REQ_TICK && wd_fire) begin
			q_push          = 1'b1;
			q_job.lin.op    = OP_ZERO;
			q_job.ang.op    = OP_ZERO;
			q_job.watchdog  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SECTORS; i++) begin
				run_min_q[i] <= NO_READING;
				lat_min_q[i] <= NO_READING;
			end
			scan_present_q <= 1'b0;
			scan_age_q     <= '0;
			cmd_age_q      <= '0;
		end else if (accept) begin
			case (s_axis_tuser)
				REQ_SAMPLE: begin
					if (s_axis_tlast) begin
						// latch including this sample, then restart the scan
						for (int i = 0; i < NUM_SECTORS; i++) begin
							lat_min_q[i] <= run_min_d[i];
							run_min_q[i] <= NO_READING;
						end
						scan_present_q <= 1'b1;
						scan_age_q     <= '0;
					end else begin
						for (int i = 0; i < NUM_SECTORS; i++) begin
							run_min_q[i] <= run_min_d[i];
						end
					end
				end
				REQ_CMD: begin
					cmd_age_q <= '0;
				end
				REQ_TICK: begin
					scan_age_q <= scan_age_inc;
					cmd_age_q  <= cmd_age_inc;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lsl_back.sv]
// Back end: applies each job's per-component action with a shared multiply and
// a bit-serial divider, and holds the result in the output register. Depends on lsl_pkg.
`default_nettype none

module lsl_back import lsl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] zone,
	input  wire logic        job_valid,
	input  wire lsl_job_t    job,
	output      logic        job_pop,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,
	output      logic [0:0]  m_axis_tuser
);

	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	lsl_bk_state_t state_q, state_d;
	lsl_job_t      job_q;
	logic          comp_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]   dv_q;
	logic          neg_q;
	logic signed [15:0] lin_res_q, ang_res_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic          out_wd_q;

	lsl_comp_t     cur;
	logic [15:0]   mag;
	logic [16:0]   sh, diff;
	logic          ge;
	logic [15:0]   quot;
	logic signed [15:0] fin_val;
	logic          fin_comp, start_div, div_step, out_load;

	assign cur  = comp_q ? job_q.ang : job_q.lin;
	assign mag  = cur.val[15] ? 16'(-cur.val) : cur.val;
	// one restoring step: the high half always stays below the divisor
	assign sh   = dv_q[31:15];
	assign ge   = sh >= {1'b0, zone};
	assign diff = sh - {1'b0, zone};
	assign quot = {dv_q[14:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		fin_comp  = 1'b0;
		fin_val   = '0;
		start_div = 1'b0;
		div_step  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				if (cur.op == OP_SCALE) begin
					start_div = 1'b1;
					state_d   = BK_DIV;
				end else begin
					fin_comp = 1'b1;
					fin_val  = (cur.op == OP_PASS) ? cur.val : '0;
					state_d  = comp_q ? BK_OUT : BK_MUL;
				end
			end
			BK_DIV: begin
				div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					fin_comp = 1'b1;
					fin_val  = neg_q ? $signed(-quot) : $signed(quot);
					state_d  = comp_q ? BK_OUT : BK_MUL;
				end
			end
			BK_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (start_div) begin
			dv_q  <= 32'(mag * cur.num);
			neg_q <= cur.val[15];
			cnt_q <= '0;
		end else if (div_step) begin
			dv_q  <= {(ge ? diff[15:0] : sh[15:0]), dv_q[14:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (fin_comp) begin
			if (comp_q) begin
				ang_res_q <= fin_val;
			end else begin
				lin_res_q <= fin_val;
			end
		end
		if (out_load) begin
			out_data_q <= {ang_res_q, lin_res_q};
			out_wd_q   <= job_q.watchdog;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				comp_q <= 1'b0;
			end else if (fin_comp) begin
				comp_q <= ~comp_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_wd_q;

endmodule

`default_nettype wire

[hw/rtl/lsl_checker.sv]
// Port-level checks for the lidar sector speed limiter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module lsl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic [0:0]  m_axis_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a watchdog stop always commands zero motion
	a_wd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
		else $error("watchdog result carries nonzero velocity");

	// no result can come out right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid straight after reset");

	// the queue starts empty, so the input is open right after reset
	a_ready_after_reset: assert property (@(posedge clk)
		!arst_n |=> s_axis_tready)
		else $error("input not ready straight after reset");

endmodule

bind lidar_sector_speed_limiter_top lsl_checker u_lsl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
